// ----- hdl/sled_pkg.sv -----
// Shared types and constants for the serial line editor with tokenizer.
// Used by sled_ctrl, sled_dp and serial_line_editor_tokenizer_top; depends on nothing.
`default_nettype none

package sled_pkg;

   localparam int LINE_MAX   = 64;
   localparam int ARG_MAX    = 8;
   localparam int CHAR_W     = 8;
   localparam int LINE_IDX_W = $clog2(LINE_MAX);
   localparam int ARG_IDX_W  = $clog2(ARG_MAX);
   localparam int ARGC_W     = $clog2(ARG_MAX + 1);

   localparam logic [CHAR_W-1:0] CH_BEL      = 8'd7;
   localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
   localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SP       = 8'd32;
   localparam logic [CHAR_W-1:0] CH_DEL      = 8'd127;
   localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
   localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;

   // Highest cursor value; a printable byte is stored only below it.
   localparam logic [LINE_IDX_W-1:0] CURSOR_LIMIT = LINE_IDX_W'(LINE_MAX - 2);
   localparam logic [ARGC_W-1:0]     ARGC_LIMIT   = ARGC_W'(ARG_MAX);

   typedef enum logic [1:0] {
      CLS_PRINT = 2'd0,
      CLS_ERASE = 2'd1,
      CLS_EOL   = 2'd2,
      CLS_OTHER = 2'd3
   } char_class_type;

   typedef enum logic [2:0] {
      OUT_CHAR = 3'd0,
      OUT_BS   = 3'd1,
      OUT_SP   = 3'd2,
      OUT_CR   = 3'd3,
      OUT_LF   = 3'd4,
      OUT_BEL  = 3'd5,
      OUT_ARG  = 3'd6
   } out_sel_type;

   typedef struct packed {
      logic        take_char;
      logic        store_char;
      logic        cursor_inc;
      logic        cursor_dec;
      logic        scan_init;
      logic        scan_step;
      logic        emit_init;
      logic        emit_next;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
      logic        out_done;
   } sled_cmd_type;

   typedef struct packed {
      char_class_type cls;
      logic           slot_free;
      logic           scan_done;
      logic           argc_zero;
      logic           emit_last;
   } sled_status_type;

endpackage

`default_nettype wire

// ----- hdl/serial_line_editor_tokenizer_top.sv -----
// Serial line editor with tokenizer, top level.
// A request is latched from the idle state, and its first result is loaded in the decode state
// once the output register is free. A new byte is taken only from idle; a line end first walks
// the buffer up to the cursor, and output stalls hold each result in the output register.
// Reset clears the cursor, the controller and the result valid flag; the buffer is not cleared.
// Instantiates sled_ctrl and sled_dp; uses sled_pkg.
`default_nettype none

module serial_line_editor_tokenizer_top (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [7:0] req_rx_char,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_echo_valid,
   output logic [7:0] rsp_echo_char,
   output logic       rsp_arg_valid,
   output logic [2:0] rsp_arg_index,
   output logic [5:0] rsp_arg_start,
   output logic [5:0] rsp_arg_length,
   output logic       rsp_line_done,
   output logic [3:0] rsp_arg_count,
   output logic       rsp_parse_fail,
   output logic       rsp_last
);

   // The controller decides what each cycle does and keeps only its state register;
   // the datapath holds all of the other storage. They talk only through these two structs.
   sled_pkg::sled_cmd_type    cmd;
   sled_pkg::sled_status_type status;

   // The controller takes one request at a time from its idle state. A request
   // is latched at once, so a result still waiting in the output register does
   // not keep the next request from being taken.
   sled_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath stores printable bytes in the line buffer, walks the buffer
   // up to the cursor at a line end to split it at spaces, and keeps a small
   // table of argument starts and lengths that is read back one entry per
   // result after the line feed echo.
   sled_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_rx_char    (req_rx_char),
      .rsp_stall      (rsp_stall),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_echo_valid (rsp_echo_valid),
      .rsp_echo_char  (rsp_echo_char),
      .rsp_arg_valid  (rsp_arg_valid),
      .rsp_arg_index  (rsp_arg_index),
      .rsp_arg_start  (rsp_arg_start),
      .rsp_arg_length (rsp_arg_length),
      .rsp_line_done  (rsp_line_done),
      .rsp_arg_count  (rsp_arg_count),
      .rsp_parse_fail (rsp_parse_fail),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ----- hdl/sled_ctrl.sv -----
// Control state machine of the serial line editor.
// Sequences echo, line scan and argument reporting; uses sled_pkg.
`default_nettype none

module sled_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  sled_pkg::sled_status_type status,
   output sled_pkg::sled_cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_SP     = 7'b0000100,
      S_BS2    = 7'b0001000,
      S_SCAN   = 7'b0010000,
      S_LF     = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_char = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               case (status.cls)
                  sled_pkg::CLS_PRINT: begin
                     cmd.out_sel    = sled_pkg::OUT_CHAR;
                     cmd.out_last   = 1'b1;
                     cmd.store_char = 1'b1;
                     cmd.cursor_inc = 1'b1;
                     state_in       = S_IDLE;
                  end
                  sled_pkg::CLS_ERASE: begin
                     cmd.out_sel = sled_pkg::OUT_BS;
                     state_in    = S_SP;
                  end
                  sled_pkg::CLS_EOL: begin
                     cmd.out_sel   = sled_pkg::OUT_CR;
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
                  default: begin
                     cmd.out_sel  = sled_pkg::OUT_BEL;
                     cmd.out_last = 1'b1;
                     state_in     = S_IDLE;
                  end
               endcase
            end
         end
         S_SP: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = sled_pkg::OUT_SP;
               state_in     = S_BS2;
            end
         end
         S_BS2: begin
            if (status.slot_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_sel    = sled_pkg::OUT_BS;
               cmd.out_last   = 1'b1;
               cmd.cursor_dec = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = S_LF;
            end
         end
         S_LF: begin
            if (status.slot_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_sel   = sled_pkg::OUT_LF;
               cmd.out_last  = status.argc_zero;
               cmd.out_done  = status.argc_zero;
               cmd.emit_init = 1'b1;
               state_in      = status.argc_zero ? S_IDLE : S_EMIT;
            end
         end
         S_EMIT: begin
            if (status.slot_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_sel   = sled_pkg::OUT_ARG;
               cmd.out_last  = status.emit_last;
               cmd.out_done  = status.emit_last;
               cmd.emit_next = 1'b1;
               if (status.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // A request is taken only from idle, and decoding always follows it.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_DECODE))
      else $error("request taken without moving to decode");

   // A result is never pushed into an output register that is still held.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.slot_free)
      else $error("result loaded over a stalled result");

   // Exactly one state bit is set at all times once out of reset.
   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register is not one-hot");

endmodule

`default_nettype wire

// ----- hdl/sled_dp.sv -----
// Datapath of the serial line editor: line buffer, cursor, scan, argument table, result register.
// Driven by sled_ctrl through command and status structs; uses sled_pkg.
`default_nettype none

module sled_dp (
   input  wire                               clock,
   input  wire                               reset,
   input  wire  [sled_pkg::CHAR_W-1:0]       req_rx_char,
   input  wire                               rsp_stall,
   input  sled_pkg::sled_cmd_type            cmd,
   output sled_pkg::sled_status_type         status,
   output logic                              rsp_valid,
   output logic                              rsp_echo_valid,
   output logic [7:0]                        rsp_echo_char,
   output logic                              rsp_arg_valid,
   output logic [2:0]                        rsp_arg_index,
   output logic [5:0]                        rsp_arg_start,
   output logic [5:0]                        rsp_arg_length,
   output logic                              rsp_line_done,
   output logic [3:0]                        rsp_arg_count,
   output logic                              rsp_parse_fail,
   output logic                              rsp_last
);

   localparam int LW = sled_pkg::LINE_IDX_W;
   localparam int AW = sled_pkg::ARG_IDX_W;
   localparam int CW = sled_pkg::ARGC_W;

   logic [sled_pkg::CHAR_W-1:0] line_mem [sled_pkg::LINE_MAX];
   logic [sled_pkg::CHAR_W-1:0] rd_data_ff;
   logic [sled_pkg::CHAR_W-1:0] char_ff;

   logic [LW-1:0] cursor_ff;
   logic [LW-1:0] len_ff;
   logic [LW-1:0] idx_ff;
   logic [LW-1:0] pos_ff;
   logic          pend_ff;
   logic          delim_ff;
   logic          fail_ff;
   logic [CW-1:0] argc_ff;
   logic [CW-1:0] argc_m1;
   logic [LW-1:0] cur_len_ff;
   logic [CW-1:0] emit_k_ff;

   logic [LW-1:0] tab_start [sled_pkg::ARG_MAX];
   logic [LW-1:0] tab_len   [sled_pkg::ARG_MAX];

   sled_pkg::char_class_type cls_sel;

   logic          is_space;
   logic          arg_open;
   logic          arg_over;
   logic          arg_grow;
   logic [AW-1:0] tab_wr_idx;
   logic          issue;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          echo_valid_ff;
   logic [7:0]    echo_char_ff;
   logic          arg_valid_ff;
   logic [2:0]    arg_index_ff;
   logic [5:0]    arg_start_ff;
   logic [5:0]    arg_length_ff;
   logic          line_done_ff;
   logic [3:0]    arg_count_ff;
   logic          parse_fail_ff;
   logic          last_ff;

   // Byte classification against the current cursor.
   always_comb begin
      if (char_ff >= sled_pkg::CH_PRINT_LO && char_ff <= sled_pkg::CH_PRINT_HI &&
          cursor_ff < sled_pkg::CURSOR_LIMIT) begin
         cls_sel = sled_pkg::CLS_PRINT;
      end else if ((char_ff == sled_pkg::CH_BS || char_ff == sled_pkg::CH_DEL) &&
                   cursor_ff != '0) begin
         cls_sel = sled_pkg::CLS_ERASE;
      end else if (char_ff == sled_pkg::CH_LF || char_ff == sled_pkg::CH_CR) begin
         cls_sel = sled_pkg::CLS_EOL;
      end else begin
         cls_sel = sled_pkg::CLS_OTHER;
      end
   end

   assign argc_m1 = argc_ff - CW'(1);
   assign status  = {cls_sel,
                     !rsp_valid_ff || !rsp_stall,
                     (idx_ff == len_ff) && !pend_ff,
                     (argc_ff == '0),
                     (emit_k_ff == argc_m1)};

   // Tokenizer step on the byte read in the previous cycle.
   assign is_space   = (rd_data_ff == sled_pkg::CH_SP);
   assign arg_open   = pend_ff && !is_space && delim_ff && (argc_ff < sled_pkg::ARGC_LIMIT);
   assign arg_over   = pend_ff && !is_space && delim_ff && !(argc_ff < sled_pkg::ARGC_LIMIT);
   assign arg_grow   = pend_ff && !is_space && !delim_ff;
   assign tab_wr_idx = arg_open ? argc_ff[AW-1:0] : argc_m1[AW-1:0];
   assign issue      = cmd.scan_step && (idx_ff != len_ff);

   // Line buffer with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store_char) begin
         line_mem[cursor_ff] <= char_ff;
      end
      rd_data_ff <= line_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_char) begin
         char_ff <= req_rx_char;
      end
      if (cmd.scan_init) begin
         len_ff <= cursor_ff;
      end
      if (issue) begin
         pos_ff <= idx_ff;
      end
      if (arg_open) begin
         tab_start[tab_wr_idx] <= pos_ff;
      end
      if (arg_open || arg_grow) begin
         tab_len[tab_wr_idx] <= arg_open ? LW'(1) : cur_len_ff + LW'(1);
         cur_len_ff          <= arg_open ? LW'(1) : cur_len_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         idx_ff    <= '0;
         pend_ff   <= 1'b0;
         delim_ff  <= 1'b1;
         fail_ff   <= 1'b0;
         argc_ff   <= '0;
         emit_k_ff <= '0;
      end else begin
         if (cmd.cursor_inc) begin
            cursor_ff <= cursor_ff + LW'(1);
         end else if (cmd.cursor_dec) begin
            cursor_ff <= cursor_ff - LW'(1);
         end else if (cmd.scan_init) begin
            cursor_ff <= '0;
         end
         if (cmd.scan_init) begin
            idx_ff   <= '0;
            pend_ff  <= 1'b0;
            delim_ff <= 1'b1;
            fail_ff  <= 1'b0;
            argc_ff  <= '0;
         end else begin
            pend_ff <= issue;
            if (issue) begin
               idx_ff <= idx_ff + LW'(1);
            end
            if (pend_ff && is_space) begin
               delim_ff <= 1'b1;
            end else if (arg_open) begin
               delim_ff <= 1'b0;
               argc_ff  <= argc_ff + CW'(1);
            end
            if (arg_over) begin
               fail_ff <= 1'b1;
            end
         end
         if (cmd.emit_init) begin
            emit_k_ff <= '0;
         end else if (cmd.emit_next) begin
            emit_k_ff <= emit_k_ff + CW'(1);
         end
      end
   end

   // Result register.
   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         echo_valid_ff <= 1'b1;
         arg_valid_ff  <= 1'b0;
         arg_index_ff  <= '0;
         arg_start_ff  <= '0;
         arg_length_ff <= '0;
         line_done_ff  <= cmd.out_done;
         arg_count_ff  <= cmd.out_done ? argc_ff : '0;
         parse_fail_ff <= cmd.out_done && fail_ff;
         last_ff       <= cmd.out_last;
         case (cmd.out_sel)
            sled_pkg::OUT_CHAR: echo_char_ff <= char_ff;
            sled_pkg::OUT_BS:   echo_char_ff <= sled_pkg::CH_BS;
            sled_pkg::OUT_SP:   echo_char_ff <= sled_pkg::CH_SP;
            sled_pkg::OUT_CR:   echo_char_ff <= sled_pkg::CH_CR;
            sled_pkg::OUT_LF:   echo_char_ff <= sled_pkg::CH_LF;
            sled_pkg::OUT_ARG: begin
               echo_valid_ff <= 1'b0;
               echo_char_ff  <= '0;
               arg_valid_ff  <= 1'b1;
               arg_index_ff  <= emit_k_ff[AW-1:0];
               arg_start_ff  <= tab_start[emit_k_ff[AW-1:0]];
               arg_length_ff <= tab_len[emit_k_ff[AW-1:0]];
            end
            default:            echo_char_ff <= sled_pkg::CH_BEL;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_echo_valid = echo_valid_ff;
   assign rsp_echo_char  = echo_char_ff;
   assign rsp_arg_valid  = arg_valid_ff;
   assign rsp_arg_index  = arg_index_ff;
   assign rsp_arg_start  = arg_start_ff;
   assign rsp_arg_length = arg_length_ff;
   assign rsp_line_done  = line_done_ff;
   assign rsp_arg_count  = arg_count_ff;
   assign rsp_parse_fail = parse_fail_ff;
   assign rsp_last       = last_ff;

   assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= sled_pkg::CURSOR_LIMIT)
      else $error("cursor ran past the line limit");

   assert property (@(posedge clock) disable iff (reset)
      fail_ff |-> (argc_ff == sled_pkg::ARGC_LIMIT))
      else $error("overflow flagged before the argument table filled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && line_done_ff) |-> last_ff)
      else $error("line completion not on the last result");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for serial_line_editor_tokenizer_top: directed bytes, then random
// lines, checked against typed echoes or an in-bench line editor model. Uses sled_pkg.

module tb_top;

   // One response beat as the block presents it on the rsp_ channel.
   typedef struct packed {
      logic       echo_valid;
      logic [7:0] echo_char;
      logic       arg_valid;
      logic [2:0] arg_index;
      logic [5:0] arg_start;
      logic [5:0] arg_length;
      logic       line_done;
      logic [3:0] arg_count;
      logic       parse_fail;
      logic       last;
   } rsp_beat_type;

   // A directed row. When known is set, the single echo of the row is typed in here;
   // otherwise the responses come from the line editor model.
   typedef struct packed {
      logic [7:0] ch;
      logic       known;
      logic [7:0] echo;
   } key_row_type;

   localparam int KEY_ROWS     = 25;
   // Random lines stop once this many more bytes are in; the last line runs over a little.
   localparam int RANDOM_BYTES = 440;
   localparam int MAX_GAP      = 18;
   // The slowest quiet stretch is a line end: the buffer scan plus up to 8 argument
   // beats and the register latency, behind a full sender gap or receiver stall.
   // The limit below leaves a wide margin over that.
   localparam int WATCHDOG_LIMIT = 3000;
   // After the last response, wait longer than the longest line-end scan.
   localparam int DRAIN_CYCLES   = 100;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_echo_valid;
   logic [7:0] rsp_echo_char;
   logic       rsp_arg_valid;
   logic [2:0] rsp_arg_index;
   logic [5:0] rsp_arg_start;
   logic [5:0] rsp_arg_length;
   logic       rsp_line_done;
   logic [3:0] rsp_arg_count;
   logic       rsp_parse_fail;
   logic       rsp_last;

   serial_line_editor_tokenizer_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_char    (req_rx_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_echo_valid (rsp_echo_valid),
      .rsp_echo_char  (rsp_echo_char),
      .rsp_arg_valid  (rsp_arg_valid),
      .rsp_arg_index  (rsp_arg_index),
      .rsp_arg_start  (rsp_arg_start),
      .rsp_arg_length (rsp_arg_length),
      .rsp_line_done  (rsp_line_done),
      .rsp_arg_count  (rsp_arg_count),
      .rsp_parse_fail (rsp_parse_fail),
      .rsp_last       (rsp_last)
   );

   // 12 ns period, 6 ns high and 6 ns low.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The model's own copy of the editor state. Only entries below the cursor are read,
   // and every one of them was written on the current line.
   logic [7:0] line_buf [sled_pkg::LINE_MAX];
   logic [5:0] edit_pos = '0;

   rsp_beat_type due_results [$];   // responses still owed by the block, oldest first
   rsp_beat_type step_results [$];  // responses caused by the byte just modeled

   int bytes_sent    = 0;
   int mismatches    = 0;
   int lines_ended   = 0;
   int arg_beats     = 0;
   int overflow_lines = 0;
   int full_rejects  = 0;
   int quiet_cycles  = 0;
   bit req_burst     = 1'b0;
   bit rsp_burst     = 1'b0;

   // Directed bytes: both ends of the byte range, both erase codes on an empty line,
   // both line-end codes on an empty line, the printable bounds, control bytes that ring
   // the bell, erase in the middle of a line, and a line that is nothing but spaces.
   key_row_type key_rows [KEY_ROWS] = '{
      '{8'h00,                 1'b1, sled_pkg::CH_BEL},
      '{8'hFF,                 1'b1, sled_pkg::CH_BEL},
      '{sled_pkg::CH_BS,       1'b1, sled_pkg::CH_BEL},
      '{sled_pkg::CH_DEL,      1'b1, sled_pkg::CH_BEL},
      '{sled_pkg::CH_CR,       1'b0, 8'h00},
      '{sled_pkg::CH_LF,       1'b0, 8'h00},
      '{8'h1B,                 1'b1, sled_pkg::CH_BEL},
      '{8'h1F,                 1'b1, sled_pkg::CH_BEL},
      '{8'h80,                 1'b1, sled_pkg::CH_BEL},
      '{sled_pkg::CH_PRINT_LO, 1'b1, sled_pkg::CH_PRINT_LO},
      '{sled_pkg::CH_PRINT_HI, 1'b1, sled_pkg::CH_PRINT_HI},
      '{sled_pkg::CH_CR,       1'b0, 8'h00},
      '{8'h41,                 1'b1, 8'h41},
      '{sled_pkg::CH_BS,       1'b0, 8'h00},
      '{8'h42,                 1'b1, 8'h42},
      '{sled_pkg::CH_DEL,      1'b0, 8'h00},
      '{8'h43,                 1'b1, 8'h43},
      '{sled_pkg::CH_SP,       1'b1, sled_pkg::CH_SP},
      '{sled_pkg::CH_SP,       1'b1, sled_pkg::CH_SP},
      '{8'h44,                 1'b1, 8'h44},
      '{8'h45,                 1'b1, 8'h45},
      '{sled_pkg::CH_LF,       1'b0, 8'h00},
      '{sled_pkg::CH_SP,       1'b1, sled_pkg::CH_SP},
      '{sled_pkg::CH_SP,       1'b1, sled_pkg::CH_SP},
      '{sled_pkg::CH_CR,       1'b0, 8'h00}
   };

   function automatic rsp_beat_type echo_beat(input logic [7:0] ch);
      rsp_beat_type b;
      b = '0;
      b.echo_valid = 1'b1;
      b.echo_char  = ch;
      return b;
   endfunction

   // Line editor model: applies one received byte to the model state and leaves the
   // responses it causes in step_results, with last set on the final one.
   task automatic edit_and_split(input logic [7:0] ch);
      int unsigned  starts [sled_pkg::ARG_MAX];
      int unsigned  lens [sled_pkg::ARG_MAX];
      int unsigned  argc;
      bit           delim;
      bit           fail;
      rsp_beat_type b;
      step_results = {};
      argc  = 0;
      delim = 1'b1;
      fail  = 1'b0;
      if (ch >= sled_pkg::CH_PRINT_LO && ch <= sled_pkg::CH_PRINT_HI &&
          edit_pos < sled_pkg::CURSOR_LIMIT) begin
         line_buf[edit_pos] = ch;
         edit_pos++;
         step_results.push_back(echo_beat(ch));
      end else if ((ch == sled_pkg::CH_BS || ch == sled_pkg::CH_DEL) && edit_pos != 0) begin
         step_results.push_back(echo_beat(sled_pkg::CH_BS));
         step_results.push_back(echo_beat(sled_pkg::CH_SP));
         step_results.push_back(echo_beat(sled_pkg::CH_BS));
         edit_pos--;
      end else if (ch == sled_pkg::CH_LF || ch == sled_pkg::CH_CR) begin
         step_results.push_back(echo_beat(sled_pkg::CH_CR));
         step_results.push_back(echo_beat(sled_pkg::CH_LF));
         // Split only the positions below the cursor; older bytes past it are stale.
         for (int i = 0; i < edit_pos; i++) begin
            if (line_buf[i] == sled_pkg::CH_SP) begin
               delim = 1'b1;
            end else if (delim) begin
               if (argc < sled_pkg::ARG_MAX) begin
                  starts[argc] = i;
                  lens[argc]   = 1;
                  argc++;
                  delim = 1'b0;
               end else begin
                  fail = 1'b1;
               end
            end else if (argc > 0) begin
               lens[argc-1]++;
            end
         end
         for (int i = 0; i < argc; i++) begin
            b = '0;
            b.arg_valid  = 1'b1;
            b.arg_index  = 3'(i);
            b.arg_start  = 6'(starts[i]);
            b.arg_length = 6'(lens[i]);
            step_results.push_back(b);
         end
         b = step_results.pop_back();
         b.line_done  = 1'b1;
         b.arg_count  = 4'(argc);
         b.parse_fail = fail;
         step_results.push_back(b);
         edit_pos = '0;
         lines_ended++;
         arg_beats += argc;
         if (fail) overflow_lines++;
      end else begin
         if (ch >= sled_pkg::CH_PRINT_LO && ch <= sled_pkg::CH_PRINT_HI) full_rejects++;
         step_results.push_back(echo_beat(sled_pkg::CH_BEL));
      end
      b = step_results.pop_back();
      b.last = 1'b1;
      step_results.push_back(b);
   endtask

   // Presents one request after a random gap and returns at the edge that accepts it.
   // The payload is scrambled while valid is low so that stale data is never trusted.
   task automatic drive_request(input logic [7:0] ch);
      int gap;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_valid   <= 1'b0;
         req_rx_char <= 8'($urandom);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_char <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_byte(input logic [7:0] ch);
      drive_request(ch);
      edit_and_split(ch);
      foreach (step_results[i]) due_results.push_back(step_results[i]);
   endtask

   // One random line. Most are words split by runs of spaces, with the odd erase or
   // stray byte, and up to eleven words so that argument overflow shows up. Some are
   // long enough to fill the buffer, and some are bare noise with no line end.
   task automatic send_text_line();
      int kind;
      int words;
      int wlen;
      int n;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
         words = $urandom_range(0, 11);
         if ($urandom_range(0, 3) == 0) send_byte(sled_pkg::CH_SP);
         for (int w = 0; w < words; w++) begin
            wlen = $urandom_range(1, 6);
            for (int j = 0; j < wlen; j++) begin
               send_byte(8'($urandom_range(33, 126)));
               if ($urandom_range(0, 11) == 0)
                  send_byte($urandom_range(0, 1) ? sled_pkg::CH_BS : sled_pkg::CH_DEL);
               if ($urandom_range(0, 29) == 0) send_byte(8'($urandom_range(0, 255)));
            end
            if (w < words - 1 || $urandom_range(0, 3) == 0) begin
               n = $urandom_range(1, 3);
               repeat (n) send_byte(sled_pkg::CH_SP);
            end
         end
      end else if (kind < 9) begin
         // Can run past the end of the buffer so that printable bytes get refused.
         n = $urandom_range(56, 72);
         repeat (n)
            send_byte($urandom_range(0, 4) == 0 ? sled_pkg::CH_SP : 8'($urandom_range(33, 126)));
      end else begin
         n = $urandom_range(1, 6);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
         return;
      end
      send_byte($urandom_range(0, 1) ? sled_pkg::CH_CR : sled_pkg::CH_LF);
   endtask

   // The receiver draws a random stall before each response, and now and
   // then switches to a stretch with no stalls at all.
   initial begin
      int n;
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         n = rsp_burst ? 0 : $urandom_range(0, MAX_GAP);
         repeat (n) @(negedge clock) rsp_stall <= 1'b1;
         @(negedge clock) rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Each accepted response is held against the oldest one still owed.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("response with none owed: echo %0h arg %0b", rsp_echo_char, rsp_arg_valid);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            check_field("echo_valid", 8'(want.echo_valid), 8'(rsp_echo_valid));
            check_field("echo_char",  want.echo_char,      rsp_echo_char);
            check_field("arg_valid",  8'(want.arg_valid),  8'(rsp_arg_valid));
            check_field("arg_index",  8'(want.arg_index),  8'(rsp_arg_index));
            check_field("arg_start",  8'(want.arg_start),  8'(rsp_arg_start));
            check_field("arg_length", 8'(want.arg_length), 8'(rsp_arg_length));
            check_field("line_done",  8'(want.line_done),  8'(rsp_line_done));
            check_field("arg_count",  8'(want.arg_count),  8'(rsp_arg_count));
            check_field("parse_fail", 8'(want.parse_fail), 8'(rsp_parse_fail));
            check_field("last",       8'(want.last),       8'(rsp_last));
         end
      end
   end

   // Watchdog: any handshake on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses owed",
                  WATCHDOG_LIMIT, due_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      rsp_beat_type b;
      // Reset is held from the start and released on a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Directed table.
      for (int r = 0; r < KEY_ROWS; r++) begin
         drive_request(key_rows[r].ch);
         edit_and_split(key_rows[r].ch);
         if (key_rows[r].known) begin
            b = echo_beat(key_rows[r].echo);
            b.last = 1'b1;
            due_results.push_back(b);
         end else begin
            foreach (step_results[i]) due_results.push_back(step_results[i]);
         end
      end

      // Random lines until enough bytes have gone in.
      while (bytes_sent < KEY_ROWS + RANDOM_BYTES) send_text_line();
      @(negedge clock) req_valid <= 1'b0;

      // Let every owed response arrive, then watch a while longer for strays.
      wait (due_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes; %0d lines ended with %0d argument beats in total.",
               bytes_sent, lines_ended, arg_beats);
      $display("Lines with too many arguments: %0d; printable bytes refused on a full line: %0d.",
               overflow_lines, full_rejects);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
